/* sv/gal_pkg.sv */
`default_nettype none

package gal_pkg;

  localparam int unsigned LevelW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegCo2Lo   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCo2Hi   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTvocLo  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTvocHi  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLongest = 3'd4;
  localparam logic [CfgIdxW-1:0] RegShortest = 3'd5;

  // Register values after reset
  localparam logic [CfgDataW-1:0] RstCo2Lo    = 16'd1000;
  localparam logic [CfgDataW-1:0] RstCo2Hi    = 16'd2000;
  localparam logic [CfgDataW-1:0] RstTvocLo   = 16'd220;
  localparam logic [CfgDataW-1:0] RstTvocHi   = 16'd660;
  localparam logic [CfgDataW-1:0] RstLongest  = 16'd2000;
  localparam logic [CfgDataW-1:0] RstShortest = 16'd100;

  typedef struct packed {
    logic [LevelW-1:0] co2_level;
    logic [LevelW-1:0] tvoc_level;
    logic [TimeW-1:0]  now_ms;
  } in_t;

  typedef struct packed {
    logic               led_on;
    logic               led_changed;
    logic               alarm_active;
    logic [PeriodW-1:0] period_ms;
  } out_t;

  // Thresholds and period bounds seen by one lane
  typedef struct packed {
    logic [LevelW-1:0]  lo;
    logic [LevelW-1:0]  hi;
    logic [PeriodW-1:0] longest;
    logic [PeriodW-1:0] shortest;
  } lane_cfg_t;

  // Lane result toward the merge stage
  typedef struct packed {
    logic               done;
    logic               alarm;
    logic [PeriodW-1:0] period;
  } lane_res_t;

endpackage

`default_nettype wire

/* sv/gal_lane.sv */
`default_nettype none

module gal_lane (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [gal_pkg::LevelW-1:0]     level_i,
  input  gal_pkg::lane_cfg_t             cfg_i,
  input  logic                           ack_i,
  output gal_pkg::lane_res_t             res_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_ADJ  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam int unsigned PW   = gal_pkg::PeriodW;
  localparam int unsigned CntW = $clog2(PW);

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [PW-1:0] diff_q, den_q, span_q, lp_q, sp_q;
  logic          alarm_q, inrange_q, up_q;
  logic [PW-1:0] rem_q, quo_q, per_q;

  logic [2*PW-1:0] prod;
  logic [PW:0]     trial;
  logic            fits;
  logic [PW-1:0]   rem_next;
  logic [PW-1:0]   ceil_quo;
  logic [PW-1:0]   per_d;

  assign prod     = (2*PW)'(diff_q) * (2*PW)'(span_q);
  assign trial    = {rem_q, quo_q[PW-1]};
  assign fits     = trial >= {1'b0, den_q};
  assign rem_next = fits ? PW'(trial - {1'b0, den_q}) : trial[PW-1:0];
  assign ceil_quo = quo_q + PW'(rem_q != '0);

  always_comb begin
    if (!alarm_q) begin
      per_d = '0;
    end else if (!inrange_q) begin
      per_d = sp_q;
    end else if (up_q) begin
      per_d = lp_q + quo_q;
    end else begin
      per_d = lp_q - ceil_quo;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = S_MUL;
      S_MUL: begin
        state_d = S_DIV;
        cnt_d   = '0;
      end
      S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(PW - 1)) state_d = S_ADJ;
      end
      S_ADJ: state_d = S_FIN;
      S_FIN: if (ack_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      diff_q    <= level_i - cfg_i.lo;
      den_q     <= cfg_i.hi - cfg_i.lo;
      alarm_q   <= level_i >= cfg_i.lo;
      inrange_q <= level_i < cfg_i.hi;
      up_q      <= cfg_i.longest < cfg_i.shortest;
      span_q    <= (cfg_i.longest < cfg_i.shortest) ? cfg_i.shortest - cfg_i.longest
                                                    : cfg_i.longest - cfg_i.shortest;
      lp_q      <= cfg_i.longest;
      sp_q      <= cfg_i.shortest;
    end
    // Numerator high half seeds the remainder; low half shifts in, quotient fills behind
    if (state_q == S_MUL) begin
      rem_q <= prod[2*PW-1:PW];
      quo_q <= prod[PW-1:0];
    end
    if (state_q == S_DIV) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[PW-2:0], fits};
    end
    if (state_q == S_ADJ) begin
      per_q <= per_d;
    end
  end

  assign res_o.done   = state_q == S_FIN;
  assign res_o.alarm  = alarm_q;
  assign res_o.period = per_q;

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && alarm_q && inrange_q) |-> rem_q < den_q)
    else $error("lane remainder not below divisor");

  a_per_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && alarm_q && inrange_q && !up_q) |-> (per_q <= lp_q && per_q >= sp_q))
    else $error("lane period outside longest/shortest range");

endmodule

`default_nettype wire

/* sv/gal_merge.sv */
`default_nettype none

module gal_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gal_pkg::lane_res_t          co2_i,
  input  gal_pkg::lane_res_t          tvoc_i,
  input  logic [gal_pkg::TimeW-1:0]   now_i,
  output logic                        ack_o,
  output logic                        done_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output gal_pkg::out_t               out_data_o
);

  localparam logic M_IDLE = 1'b0;
  localparam logic M_UPD  = 1'b1;

  localparam int unsigned TW = gal_pkg::TimeW;
  localparam int unsigned PW = gal_pkg::PeriodW;

  logic          mst_q, mst_d;
  logic          alarm_q;
  logic [PW-1:0] period_q;
  logic [TW-1:0] last_q, last_d;
  logic          led_q, led_d;
  logic          out_valid_q;
  gal_pkg::out_t out_q;

  logic          grab, upd, out_free, changed;
  logic [PW-1:0] comb_period;
  logic [TW-1:0] last_eff, elapsed;

  assign grab     = mst_q == M_IDLE && co2_i.done && tvoc_i.done;
  assign out_free = !out_valid_q || !out_stall_i;
  assign upd      = mst_q == M_UPD && out_free;
  assign ack_o    = grab;
  assign done_o   = upd;

  always_comb begin
    if (co2_i.alarm && tvoc_i.alarm) begin
      comb_period = (co2_i.period < tvoc_i.period) ? co2_i.period : tvoc_i.period;
    end else if (co2_i.alarm) begin
      comb_period = co2_i.period;
    end else if (tvoc_i.alarm) begin
      comb_period = tvoc_i.period;
    end else begin
      comb_period = '0;
    end
  end

  // Time going backwards restarts the toggle reference at zero
  assign last_eff = (now_i < last_q) ? '0 : last_q;
  assign elapsed  = now_i - last_eff;

  always_comb begin
    led_d   = led_q;
    last_d  = last_eff;
    changed = 1'b0;
    if (!alarm_q) begin
      if (led_q) begin
        led_d   = 1'b0;
        changed = 1'b1;
      end
    end else if (elapsed >= TW'(period_q)) begin
      led_d   = !led_q;
      last_d  = now_i;
      changed = 1'b1;
    end
  end

  always_comb begin
    mst_d = mst_q;
    unique case (mst_q)
      M_IDLE: if (grab) mst_d = M_UPD;
      M_UPD:  if (out_free) mst_d = M_IDLE;
      default: mst_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mst_q       <= M_IDLE;
      last_q      <= '0;
      led_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mst_q <= mst_d;
      if (upd) begin
        last_q      <= last_d;
        led_q       <= led_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grab) begin
      alarm_q  <= co2_i.alarm || tvoc_i.alarm;
      period_q <= comb_period;
    end
    if (upd) begin
      out_q.led_on       <= led_d;
      out_q.led_changed  <= changed;
      out_q.alarm_active <= alarm_q;
      out_q.period_ms    <= period_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_changed_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd |=> out_q.led_changed == (led_q != $past(led_q)))
    else $error("led_changed does not match LED transition");

  a_off_without_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd && !alarm_q) |=> !led_q)
    else $error("LED lit without alarm");

endmodule

`default_nettype wire

/* sv/gas_level_alarm_blinker.sv */
// Gas level alarm blinker. Each transfer on the input channel carries a CO2
// sample, a TVOC sample and the current millisecond time; each one yields
// exactly one result transfer with the LED drive, whether it changed, whether
// any gas is at or above its low threshold, and the chosen blink half-period
// (zero without alarm). Two lanes, one per gas, compute their periods side by
// side: a 16x16 multiply followed by a 16-step restoring divider. A merge
// stage then takes the smaller active period and updates the LED and the
// toggle time, registering the result; the next item is taken in the cycle
// after the result is registered, even while that result still waits
// downstream. Configuration registers (indexes 0..5: CO2 low/high, TVOC
// low/high, longest and shortest period) are to be written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i only while the block is idle; the block
// itself does not enforce this. Indexes beyond the list are ignored.
`default_nettype none

module gas_level_alarm_blinker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gal_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [gal_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  gal_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output gal_pkg::out_t                     out_data_o
);

  // Configuration registers
  logic [gal_pkg::CfgDataW-1:0] co2_lo_q, co2_hi_q, tvoc_lo_q, tvoc_hi_q;
  logic [gal_pkg::CfgDataW-1:0] longest_q, shortest_q;

  logic                      busy_q;
  logic                      accept;
  logic [gal_pkg::TimeW-1:0] now_q;
  logic                      ack, done;

  gal_pkg::lane_cfg_t co2_cfg, tvoc_cfg;
  gal_pkg::lane_res_t co2_res, tvoc_res;

  // Hold off new input while an item is in the lanes or merge stage
  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      co2_lo_q   <= gal_pkg::RstCo2Lo;
      co2_hi_q   <= gal_pkg::RstCo2Hi;
      tvoc_lo_q  <= gal_pkg::RstTvocLo;
      tvoc_hi_q  <= gal_pkg::RstTvocHi;
      longest_q  <= gal_pkg::RstLongest;
      shortest_q <= gal_pkg::RstShortest;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gal_pkg::RegCo2Lo:    co2_lo_q   <= cfg_wdata_i;
        gal_pkg::RegCo2Hi:    co2_hi_q   <= cfg_wdata_i;
        gal_pkg::RegTvocLo:   tvoc_lo_q  <= cfg_wdata_i;
        gal_pkg::RegTvocHi:   tvoc_hi_q  <= cfg_wdata_i;
        gal_pkg::RegLongest:  longest_q  <= cfg_wdata_i;
        gal_pkg::RegShortest: shortest_q <= cfg_wdata_i;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Busy from input transfer until the merge stage registers the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= in_data_i.now_ms;
    end
  end

  assign co2_cfg.lo        = co2_lo_q;
  assign co2_cfg.hi        = co2_hi_q;
  assign co2_cfg.longest   = longest_q;
  assign co2_cfg.shortest  = shortest_q;
  assign tvoc_cfg.lo       = tvoc_lo_q;
  assign tvoc_cfg.hi       = tvoc_hi_q;
  assign tvoc_cfg.longest  = longest_q;
  assign tvoc_cfg.shortest = shortest_q;

  // Both lanes start together and finish in lockstep
  gal_lane u_lane_co2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .level_i (in_data_i.co2_level),
    .cfg_i   (co2_cfg),
    .ack_i   (ack),
    .res_o   (co2_res)
  );

  gal_lane u_lane_tvoc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .level_i (in_data_i.tvoc_level),
    .cfg_i   (tvoc_cfg),
    .ack_i   (ack),
    .res_o   (tvoc_res)
  );

  // Combine the lane periods, advance the LED state, register the result
  gal_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .co2_i       (co2_res),
    .tvoc_i      (tvoc_res),
    .now_i       (now_q),
    .ack_o       (ack),
    .done_o      (done),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
